// ===== rtl/core/pfr_pkg.sv =====
// shared constants, types and register codes for the png forward row filter
// no dependencies
`timescale 1ns / 1ps

package pfr_pkg;

    localparam int MAX_ROW_BYTES   = 4096;
    localparam int MAX_PIXEL_BYTES = 8;

    localparam int ROW_ADDR_W = $clog2(MAX_ROW_BYTES);
    localparam int PIX_IDX_W  = (MAX_PIXEL_BYTES > 1) ? $clog2(MAX_PIXEL_BYTES) : 1;

    localparam int BYTE_W     = 8;
    localparam int FILT_W     = 3;
    localparam int BPP_W      = 4;
    localparam int LEN_W      = 13;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 13;

    // filter type codes
    localparam logic [FILT_W-1:0] FILT_NONE  = 3'd0;
    localparam logic [FILT_W-1:0] FILT_SUB   = 3'd1;
    localparam logic [FILT_W-1:0] FILT_UP    = 3'd2;
    localparam logic [FILT_W-1:0] FILT_AVG   = 3'd3;
    localparam logic [FILT_W-1:0] FILT_PAETH = 3'd4;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_FILTER_TYPE     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BYTES_PER_PIXEL = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ROW_LENGTH      = 2'd2;

    // effective (range-limited) configuration
    typedef struct packed {
        logic [FILT_W-1:0]    filter_type;
        logic [BPP_W-1:0]     bpp;
        logic [PIX_IDX_W-1:0] bpp_idx;
        logic [LEN_W-1:0]     row_len;
    } cfg_t;

    // neighbour bytes of one raw byte
    typedef struct packed {
        logic [BYTE_W-1:0] a;
        logic [BYTE_W-1:0] b;
        logic [BYTE_W-1:0] c;
    } nbr_t;

endpackage

// ===== rtl/core/pfr_ram.sv =====
// generic single-clock ram, one write port and one registered read port
// read-first: a read and a write of the same entry in one cycle returns the old data
`timescale 1ns / 1ps

module pfr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4096
) (
    input  logic                         aclk,
    input  logic                         we,
    input  logic [$clog2(DEPTH)-1:0]     waddr,
    input  logic [WIDTH-1:0]             wdata,
    input  logic                         re,
    input  logic [$clog2(DEPTH)-1:0]     raddr,
    output logic [WIDTH-1:0]             rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/core/pfr_cfg_regs.sv =====
// configuration registers with range limiting of pixel size and row length
// depends on pfr_pkg
`timescale 1ns / 1ps

module pfr_cfg_regs import pfr_pkg::*; (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    output cfg_t                  cfg
);

    logic [FILT_W-1:0] filter_type_reg;
    logic [BPP_W-1:0]  bpp_reg;
    logic [LEN_W-1:0]  row_len_reg;
    logic [BPP_W-1:0]  bpp_eff;
    logic [LEN_W-1:0]  len_eff;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            filter_type_reg <= FILT_NONE;
            bpp_reg         <= BPP_W'(1);
            row_len_reg     <= LEN_W'(1);
        end else if (cfg_we) begin
            case (cfg_index)
                CFG_FILTER_TYPE:     filter_type_reg <= cfg_wdata[FILT_W-1:0];
                CFG_BYTES_PER_PIXEL: bpp_reg         <= cfg_wdata[BPP_W-1:0];
                CFG_ROW_LENGTH:      row_len_reg     <= cfg_wdata[LEN_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        if (bpp_reg == '0) begin
            bpp_eff = BPP_W'(1);
        end else if (bpp_reg > BPP_W'(MAX_PIXEL_BYTES)) begin
            bpp_eff = BPP_W'(MAX_PIXEL_BYTES);
        end else begin
            bpp_eff = bpp_reg;
        end
        if (row_len_reg == '0) begin
            len_eff = LEN_W'(1);
        end else if (row_len_reg > LEN_W'(MAX_ROW_BYTES)) begin
            len_eff = LEN_W'(MAX_ROW_BYTES);
        end else begin
            len_eff = row_len_reg;
        end
    end

    always_comb begin
        cfg.filter_type = filter_type_reg;
        cfg.bpp         = bpp_eff;
        cfg.bpp_idx     = PIX_IDX_W'(bpp_eff - BPP_W'(1));
        cfg.row_len     = len_eff;
    end

endmodule

// ===== rtl/core/pfr_predict.sv =====
// predictor selection and residual: none, sub, up, average, paeth
// depends on pfr_pkg
`timescale 1ns / 1ps

module pfr_predict import pfr_pkg::*; (
    input  logic [FILT_W-1:0] filter_type,
    input  nbr_t              nbr,
    input  logic [BYTE_W-1:0] raw_byte,
    output logic [BYTE_W-1:0] filtered_byte
);

    logic [BYTE_W:0]   sum_ab;
    logic [BYTE_W:0]   twice_c;
    logic [BYTE_W-1:0] pa;
    logic [BYTE_W-1:0] pb;
    logic [BYTE_W:0]   pc;
    logic [BYTE_W-1:0] paeth;
    logic [BYTE_W-1:0] pred;

    always_comb begin
        sum_ab  = {1'b0, nbr.a} + {1'b0, nbr.b};
        twice_c = {nbr.c, 1'b0};
        pa = (nbr.b > nbr.c) ? nbr.b - nbr.c : nbr.c - nbr.b;
        pb = (nbr.a > nbr.c) ? nbr.a - nbr.c : nbr.c - nbr.a;
        pc = (sum_ab > twice_c) ? sum_ab - twice_c : twice_c - sum_ab;

        // tie order a, b, c
        if ({1'b0, pa} <= {1'b0, pb} && {1'b0, pa} <= pc) begin
            paeth = nbr.a;
        end else if ({1'b0, pb} <= pc) begin
            paeth = nbr.b;
        end else begin
            paeth = nbr.c;
        end

        case (filter_type)
            FILT_SUB:   pred = nbr.a;
            FILT_UP:    pred = nbr.b;
            FILT_AVG:   pred = sum_ab[BYTE_W:1];
            FILT_PAETH: pred = paeth;
            default:    pred = '0;
        endcase

        filtered_byte = raw_byte - pred;
    end

endmodule

// ===== rtl/core/png_forward_row_filter_unit.sv =====
// png forward row filter top level: line store, neighbour history, output register
// depends on pfr_pkg, pfr_ram, pfr_cfg_regs, pfr_predict
`timescale 1ns / 1ps

// One raw byte in and one filtered byte out per clock while the output is not
// stalled. A word accepted at an edge reads the previous row's byte from the line
// store and writes its own raw byte to the same entry at that edge (the store
// returns the old contents); the inner stage then forms the predictor and loads
// the output register once that register is free, so a result is offered from
// the output register, and the sustained rate is one word per cycle when the
// output does not stall, set by the single read and write port of the line store.
// The store needs no clearing after reset; rows flagged with no prior row ignore it.
// Configuration may only be written while no word is in flight.
module png_forward_row_filter_unit import pfr_pkg::*; (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic [BYTE_W-1:0]     s_raw_byte,
    input  logic                  s_no_prior_row,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [BYTE_W-1:0]     m_filtered_byte,
    output logic                  m_row_end
);

    cfg_t cfg;

    logic                  s_accept;
    logic                  out_free;
    logic                  st1_adv;

    logic [ROW_ADDR_W-1:0] pos_reg;
    logic [ROW_ADDR_W-1:0] pos_next;
    logic                  last;
    logic                  has_left;

    logic [BYTE_W-1:0]     left_hist_reg [MAX_PIXEL_BYTES];
    logic [BYTE_W-1:0]     ul_hist_reg   [MAX_PIXEL_BYTES];

    logic                  st1_valid_reg;
    logic [BYTE_W-1:0]     st1_raw_reg;
    logic                  st1_no_prior_reg;
    logic                  st1_has_left_reg;
    logic                  st1_last_reg;
    logic [BYTE_W-1:0]     st1_a_reg;

    logic [BYTE_W-1:0]     stored;
    nbr_t                  nbr;
    logic [BYTE_W-1:0]     filtered;

    logic                  m_valid_reg;
    logic [BYTE_W-1:0]     m_filtered_byte_reg;
    logic                  m_row_end_reg;

    pfr_cfg_regs u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    assign out_free = !m_valid_reg || m_ready;
    assign st1_adv  = st1_valid_reg && out_free;
    assign s_ready  = !st1_valid_reg || out_free;
    assign s_accept = s_valid && s_ready;

    always_comb begin
        last     = (LEN_W'(pos_reg) + LEN_W'(1)) >= cfg.row_len;
        has_left = LEN_W'(pos_reg) >= LEN_W'(cfg.bpp);
        pos_next = last ? '0 : pos_reg + ROW_ADDR_W'(1);
    end

    // previous row; read and overwritten by the same word
    pfr_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (MAX_ROW_BYTES)
    ) u_line_store (
        .aclk  (aclk),
        .we    (s_accept),
        .waddr (pos_reg),
        .wdata (s_raw_byte),
        .re    (s_accept),
        .raddr (pos_reg),
        .rdata (stored)
    );

    // column counter and raw byte history, advanced on accept
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg <= '0;
            for (int i = 0; i < MAX_PIXEL_BYTES; i++) begin
                left_hist_reg[i] <= '0;
            end
        end else if (s_accept) begin
            pos_reg          <= pos_next;
            left_hist_reg[0] <= s_raw_byte;
            for (int i = 1; i < MAX_PIXEL_BYTES; i++) begin
                left_hist_reg[i] <= left_hist_reg[i-1];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st1_valid_reg <= 1'b0;
        end else if (s_accept) begin
            st1_valid_reg <= 1'b1;
        end else if (st1_adv) begin
            st1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            st1_raw_reg      <= s_raw_byte;
            st1_no_prior_reg <= s_no_prior_row;
            st1_has_left_reg <= has_left;
            st1_last_reg     <= last;
            st1_a_reg        <= has_left ? left_hist_reg[cfg.bpp_idx] : '0;
        end
    end

    // store bytes history, pushed as each word leaves the inner stage
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < MAX_PIXEL_BYTES; i++) begin
                ul_hist_reg[i] <= '0;
            end
        end else if (st1_adv) begin
            ul_hist_reg[0] <= stored;
            for (int i = 1; i < MAX_PIXEL_BYTES; i++) begin
                ul_hist_reg[i] <= ul_hist_reg[i-1];
            end
        end
    end

    always_comb begin
        nbr.a = st1_a_reg;
        nbr.b = st1_no_prior_reg ? '0 : stored;
        nbr.c = (!st1_no_prior_reg && st1_has_left_reg) ? ul_hist_reg[cfg.bpp_idx] : '0;
    end

    pfr_predict u_predict (
        .filter_type   (cfg.filter_type),
        .nbr           (nbr),
        .raw_byte      (st1_raw_reg),
        .filtered_byte (filtered)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (st1_adv) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (st1_adv) begin
            m_filtered_byte_reg <= filtered;
            m_row_end_reg       <= st1_last_reg;
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_filtered_byte = m_filtered_byte_reg;
    assign m_row_end       = m_row_end_reg;

endmodule

// ===== rtl/core/pfr_checker.sv =====
// port-level checks for the png forward row filter, bound to the top level
// depends on pfr_pkg and png_forward_row_filter_unit
`timescale 1ns / 1ps

module pfr_checker import pfr_pkg::*; (
    input logic              aclk,
    input logic              aresetn,
    input logic              s_valid,
    input logic              s_ready,
    input logic              m_valid,
    input logic              m_ready,
    input logic [BYTE_W-1:0] m_filtered_byte,
    input logic              m_row_end
);

    // reset leaves the pipe empty and ready
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> (!m_valid && s_ready))
        else $error("pipe not empty after reset");

    // a word taken while the output stalls fills the inner stage
    a_backpressure: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && m_valid && !m_ready) ##1 (m_valid && !m_ready)
        |-> !s_ready)
        else $error("input taken beyond pipe capacity");

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> m_valid)
        else $error("result word dropped before it was taken");

    a_out_stable: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> ($stable(m_filtered_byte) && $stable(m_row_end)))
        else $error("stalled result word changed");

endmodule

bind png_forward_row_filter_unit pfr_checker u_pfr_checker (
    .aclk            (aclk),
    .aresetn         (aresetn),
    .s_valid         (s_valid),
    .s_ready         (s_ready),
    .m_valid         (m_valid),
    .m_ready         (m_ready),
    .m_filtered_byte (m_filtered_byte),
    .m_row_end       (m_row_end)
);

// ===== tb/testbench.sv =====
// self-checking testbench for png_forward_row_filter_unit: reset defaults, directed
// rows per filter, range limits, then randomised rows under changing pacing and settings
// depends on pfr_pkg and the png forward row filter rtl
`timescale 1ns / 1ps

module testbench;
    import pfr_pkg::*;

    localparam int WATCHDOG_LIMIT = 4000;
    localparam int TAIL_CYCLES    = 8;
    localparam int RANDOM_WORDS   = 1650;
    localparam int REPORT_LINES   = 40;

    // codes the block treats as no filtering
    localparam logic [FILT_W-1:0] FILT_RESERVED_LO = 3'd5;
    localparam logic [FILT_W-1:0] FILT_RESERVED_HI = 3'd7;

    typedef enum logic [1:0] {
        PACE_FULL,
        PACE_SENDER_GAPS,
        PACE_RECEIVER_STALLS,
        PACE_BOTH
    } pace_t;

    typedef struct {
        logic [BYTE_W-1:0] filtered;
        logic              row_end;
    } filt_result_t;

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = CFG_FILTER_TYPE;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;
    logic                  s_valid = 1'b0;
    logic                  s_ready;
    logic [BYTE_W-1:0]     s_raw_byte = '0;
    logic                  s_no_prior_row = 1'b0;
    logic                  m_valid;
    logic                  m_ready = 1'b0;
    logic [BYTE_W-1:0]     m_filtered_byte;
    logic                  m_row_end;

    // predictor state
    logic [BYTE_W-1:0] line_store [MAX_ROW_BYTES];
    bit                line_known [MAX_ROW_BYTES];
    logic [BYTE_W-1:0] left_hist [MAX_PIXEL_BYTES];
    logic [BYTE_W-1:0] upleft_hist [MAX_PIXEL_BYTES];
    bit                upleft_known [MAX_PIXEL_BYTES];
    int unsigned       col_pos;
    logic [FILT_W-1:0] cfg_filter;
    logic [BPP_W-1:0]  cfg_bpp;
    logic [LEN_W-1:0]  cfg_len;

    filt_result_t pending_results [$];
    filt_result_t head;

    int gap_pct;
    int stall_pct;
    int mismatch_count;
    int idle_cycles;
    int words_sent;
    int results_checked;
    int rows_ended;
    int settings_written;
    int random_words;
    bit row_fresh;

    png_forward_row_filter_unit dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_we          (cfg_we),
        .cfg_index       (cfg_index),
        .cfg_wdata       (cfg_wdata),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_raw_byte      (s_raw_byte),
        .s_no_prior_row  (s_no_prior_row),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_filtered_byte (m_filtered_byte),
        .m_row_end       (m_row_end)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        m_ready <= ($urandom_range(99) >= stall_pct);
    end

    task automatic report_mismatch(input string what);
        mismatch_count++;
        if (mismatch_count <= REPORT_LINES) begin
            $display("mismatch at %0t: %s", $time, what);
        end
    endtask

    function automatic int unsigned eff_bpp();
        if (cfg_bpp == 0) return 1;
        if (cfg_bpp > MAX_PIXEL_BYTES) return MAX_PIXEL_BYTES;
        return cfg_bpp;
    endfunction

    // a word may only look at the prior row where that row was really written
    function automatic logic must_start_fresh();
        int unsigned bpp;
        bpp = eff_bpp();
        return !line_known[col_pos] || (col_pos >= bpp && !upleft_known[bpp-1]);
    endfunction

    function automatic int paeth_pick(input int a, input int b, input int c);
        int pa;
        int pb;
        int pc;
        pa = (b > c) ? b - c : c - b;
        pb = (a > c) ? a - c : c - a;
        pc = (a + b > 2 * c) ? a + b - 2 * c : 2 * c - a - b;
        if (pa <= pb && pa <= pc) return a;
        if (pb <= pc) return b;
        return c;
    endfunction

    task automatic predict_filter(input logic [BYTE_W-1:0] raw, input logic no_prior);
        int unsigned  bpp;
        int unsigned  len;
        int unsigned  pos;
        int           a;
        int           b;
        int           c;
        int           pred;
        bit           has_left;
        logic [BYTE_W-1:0] stored;
        bit           stored_known;
        filt_result_t r;
        bpp = eff_bpp();
        len = (cfg_len == 0) ? 1 : ((cfg_len > MAX_ROW_BYTES) ? MAX_ROW_BYTES : cfg_len);
        pos = col_pos;
        has_left = (pos >= bpp);
        stored = line_store[pos];
        stored_known = line_known[pos];
        a = 0;
        b = 0;
        c = 0;
        if (has_left) a = left_hist[bpp-1];
        if (!no_prior) begin
            b = stored;
            if (has_left) c = upleft_hist[bpp-1];
        end
        for (int k = MAX_PIXEL_BYTES - 1; k > 0; k--) begin
            upleft_hist[k] = upleft_hist[k-1];
            upleft_known[k] = upleft_known[k-1];
            left_hist[k] = left_hist[k-1];
        end
        upleft_hist[0] = stored;
        upleft_known[0] = stored_known;
        left_hist[0] = raw;
        case (cfg_filter)
            FILT_SUB:   pred = a;
            FILT_UP:    pred = b;
            FILT_AVG:   pred = (a + b) >> 1;
            FILT_PAETH: pred = paeth_pick(a, b, c);
            default:    pred = 0;
        endcase
        line_store[pos] = raw;
        line_known[pos] = 1'b1;
        r.filtered = BYTE_W'(int'(raw) - pred);
        r.row_end = (pos + 1 >= len);
        col_pos = r.row_end ? 0 : pos + 1;
        if (r.row_end) rows_ended++;
        pending_results.push_back(r);
    endtask

    task automatic set_pace(input pace_t p);
        case (p)
            PACE_FULL:            begin gap_pct = 0;  stall_pct = 0;  end
            PACE_SENDER_GAPS:     begin gap_pct = 54; stall_pct = 0;  end
            PACE_RECEIVER_STALLS: begin gap_pct = 0;  stall_pct = 54; end
            default:              begin gap_pct = 24; stall_pct = 24; end
        endcase
    endtask

    task automatic send_word(input logic [BYTE_W-1:0] raw, input logic want_no_prior);
        logic np;
        np = want_no_prior | must_start_fresh();
        if ($urandom_range(99) < gap_pct) begin
            do begin
                s_valid <= 1'b0;
                @(posedge aclk);
            end while ($urandom_range(99) < gap_pct);
        end
        s_valid <= 1'b1;
        s_raw_byte <= raw;
        s_no_prior_row <= np;
        do @(posedge aclk); while (!s_ready);
        words_sent++;
        predict_filter(raw, np);
    endtask

    // never returns without waiting for a clock edge, so valid is seen low before any write
    task automatic wait_drained();
        s_valid <= 1'b0;
        do @(posedge aclk); while (pending_results.size() != 0);
    endtask

    task automatic configure(input logic [FILT_W-1:0] filt, input int unsigned bpp,
                             input int unsigned len);
        wait_drained();
        cfg_we <= 1'b1;
        cfg_index <= CFG_FILTER_TYPE;
        cfg_wdata <= CFG_DATA_W'(filt);
        @(posedge aclk);
        cfg_index <= CFG_BYTES_PER_PIXEL;
        cfg_wdata <= CFG_DATA_W'(bpp);
        @(posedge aclk);
        cfg_index <= CFG_ROW_LENGTH;
        cfg_wdata <= CFG_DATA_W'(len);
        @(posedge aclk);
        cfg_we <= 1'b0;
        cfg_filter = filt;
        cfg_bpp = BPP_W'(bpp);
        cfg_len = LEN_W'(len);
        settings_written++;
    endtask

    // reset settings: no filter, one-byte rows
    task automatic test_defaults();
        set_pace(PACE_FULL);
        send_word(8'hFF, 1'b1);
        send_word(8'h00, 1'b0);
    endtask

    task automatic test_each_filter();
        logic [FILT_W-1:0] filt;
        logic [31:0]       pattern;
        for (int r = 0; r < 7; r++) begin
            case (r)
                0:       begin filt = FILT_PAETH;       pattern = 32'h00FF8001; end
                1:       begin filt = FILT_SUB;         pattern = 32'hFF00FF00; end
                2:       begin filt = FILT_UP;          pattern = 32'h00FF7F80; end
                3:       begin filt = FILT_AVG;         pattern = 32'hFFFF0100; end
                4:       begin filt = FILT_PAETH;       pattern = 32'h55555555; end
                5:       begin filt = FILT_PAETH;       pattern = 32'h55555555; end
                default: begin filt = FILT_RESERVED_LO; pattern = 32'h807F00FF; end
            endcase
            configure(filt, 1, 4);
            // first row has nothing above, so paeth falls back to sub
            for (int k = 0; k < 4; k++) begin
                send_word(pattern[31-8*k -: 8], r == 0);
            end
        end
    endtask

    task automatic test_range_limits();
        set_pace(PACE_BOTH);
        configure(FILT_SUB, 0, 0);
        for (int k = 0; k < 3; k++) send_word(8'(k * 85), 1'b0);
        configure(FILT_AVG, 15, 8191);
        for (int k = 0; k < 20; k++) send_word(8'($urandom_range(255)), 1'b0);
        // shrink the row while mid-row: next word must close it
        configure(FILT_PAETH, MAX_PIXEL_BYTES, 5);
        for (int k = 0; k < 12; k++) send_word(8'($urandom_range(255)), 1'b0);
        configure(FILT_RESERVED_HI, 2, MAX_ROW_BYTES);
        for (int k = 0; k < 10; k++) send_word(8'($urandom_range(255)), 1'b0);
    endtask

    task automatic test_random_rows();
        int unsigned       phase;
        int unsigned       n;
        int unsigned       lsel;
        int unsigned       len;
        int unsigned       bpp;
        logic [FILT_W-1:0] filt;
        logic [BYTE_W-1:0] raw;
        logic              np;
        phase = 0;
        while (random_words < RANDOM_WORDS) begin
            if ($urandom_range(9) < 8) filt = FILT_W'($urandom_range(4));
            else filt = FILT_W'($urandom_range(7, 5));
            if ($urandom_range(9) == 0) bpp = $urandom_range(1) ? 0 : $urandom_range(15, 9);
            else bpp = $urandom_range(MAX_PIXEL_BYTES, 1);
            lsel = $urandom_range(99);
            if (lsel < 70)      len = $urandom_range(24, 1);
            else if (lsel < 92) len = $urandom_range(200, 25);
            else if (lsel < 99) len = $urandom_range(1024, 201);
            else                len = MAX_ROW_BYTES;
            configure(filt, bpp, len);
            set_pace(pace_t'(phase % 4));
            n = $urandom_range(110, 30);
            for (int unsigned i = 0; i < n; i++) begin
                if (col_pos == 0) row_fresh = ($urandom_range(7) == 0);
                // now and then a flag that flips mid-row
                if ($urandom_range(19) == 0) np = $urandom_range(1);
                else np = row_fresh;
                case ($urandom_range(7))
                    0:       raw = 8'h00;
                    1:       raw = 8'hFF;
                    default: raw = 8'($urandom_range(255));
                endcase
                send_word(raw, np);
                random_words++;
            end
            phase++;
        end
    endtask

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (pending_results.size() == 0) begin
                report_mismatch("result word with nothing pending");
            end else begin
                head = pending_results.pop_front();
                if (m_filtered_byte !== head.filtered) begin
                    report_mismatch($sformatf("filtered_byte %h, want %h",
                                              m_filtered_byte, head.filtered));
                end
                if (m_row_end !== head.row_end) begin
                    report_mismatch($sformatf("row_end %b, want %b", m_row_end, head.row_end));
                end
                results_checked++;
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles == WATCHDOG_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    initial begin
        for (int k = 0; k < MAX_ROW_BYTES; k++) begin
            line_store[k] = '0;
            line_known[k] = 1'b0;
        end
        for (int k = 0; k < MAX_PIXEL_BYTES; k++) begin
            left_hist[k] = '0;
            upleft_hist[k] = '0;
            upleft_known[k] = 1'b1;
        end
        col_pos = 0;
        cfg_filter = FILT_NONE;
        cfg_bpp = 1;
        cfg_len = 1;
        set_pace(PACE_FULL);
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_defaults();
        test_each_filter();
        test_range_limits();
        test_random_rows();

        wait_drained();
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (pending_results.size() != 0) begin
            report_mismatch($sformatf("%0d results never arrived", pending_results.size()));
        end
        $display("summary: %0d words filtered, %0d results checked, %0d rows closed",
                 words_sent, results_checked, rows_ended);
        $display("summary: %0d register settings, %0d mismatches",
                 settings_written, mismatch_count);
        if (mismatch_count == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
